### rtl/core/ultrasonic_echo_ranger_unit_assert.svh
// Assertion macros for the ultrasonic echo ranger RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef ULTRASONIC_ECHO_RANGER_UNIT_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define UER_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define UER_NEVER(lbl, clk, rst_n, expr, msg) \
    `UER_ASSERT(lbl, clk, rst_n, !(expr), msg)
`else
`define UER_ASSERT(lbl, clk, rst_n, prop, msg)
`define UER_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

### rtl/core/uer_pkg.sv
// Shared types and constants of the ultrasonic echo ranger.
// No dependencies.
`default_nettype none
package uer_pkg;

    localparam int unsigned TIMEOUT_W  = 8;
    localparam int unsigned SCALE_W    = 12;
    localparam int unsigned DIST_W     = 14;
    localparam int unsigned TICKS_W    = TIMEOUT_W + 1;
    localparam int unsigned PROD_W     = 21;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 12;

    // floor(x / 100) == (x * DIV100_MUL) >> DIV100_SHIFT for any x < 2**PROD_W
    localparam int unsigned DIV100_SHIFT = 28;
    localparam int unsigned DIV100_W     = 22;
    localparam logic [DIV100_W-1:0] DIV100_MUL = 22'd2684355;
    localparam int unsigned DIV_FULL_W = PROD_W + DIV100_W;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 8'd60;
    localparam logic [SCALE_W-1:0]   SCALE_RST   = 12'd1716;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIMEOUT = 2'd0,
        REG_SCALE   = 2'd1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        PH_IDLE         = 3'd0,
        PH_TRIG_HIGH    = 3'd1,
        PH_FIRST_SAMPLE = 3'd2,
        PH_WAIT_RISE    = 3'd3,
        PH_MEASURE      = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        ERR_OK      = 2'd0,
        ERR_NO_RISE = 2'd1,
        ERR_TOO_LONG = 2'd2,
        ERR_FAULT   = 2'd3
    } t_err;

    typedef struct packed {
        logic start_req;
        logic echo;
        logic read_fault;
    } t_in_item;

    typedef struct packed {
        logic              trigger;
        logic              busy_res;
        logic              done_res;
        t_err              error_code;
        logic [DIST_W-1:0] range_cm;
    } t_out_item;

    // Control results of one tick, before the distance divide.
    typedef struct packed {
        logic              trigger;
        logic              busy;
        logic              done;
        t_err              err;
        logic              upd;
        logic [PROD_W-1:0] prod;
    } t_mid;

endpackage
`default_nettype wire

### rtl/core/uer_ctrl.sv
// Measurement sequencer: phase FSM, tick counter, pulse length times scale.
// Depends on uer_pkg and the assertion macro header.
`default_nettype none
`include "ultrasonic_echo_ranger_unit_assert.svh"
module uer_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  logic                              i_in_v,
    input  uer_pkg::t_in_item                 i_item,
    input  logic [uer_pkg::TIMEOUT_W-1:0]     i_timeout,
    input  logic [uer_pkg::SCALE_W-1:0]       i_scale,
    output logic                              o_mid_v,
    output uer_pkg::t_mid                     o_mid
);
    import uer_pkg::*;

    t_phase                r_phase;
    t_phase                n_phase;
    logic [TIMEOUT_W-1:0]  r_tick;
    logic [TIMEOUT_W-1:0]  n_tick;
    logic                  r_mid_v;
    t_mid                  r_mid;
    t_mid                  n_mid;

    logic                  w_step;
    logic                  w_trig;
    logic                  w_done;
    t_err                  w_err;
    logic                  w_upd;
    logic                  w_tmo;
    logic [TICKS_W-1:0]    w_ticks;

    assign w_step  = i_load && i_in_v;
    assign w_tmo   = (r_tick >= i_timeout);
    assign w_ticks = {1'b0, r_tick} + TICKS_W'(1);

    // outputs of this tick
    always_comb begin
        w_trig = 1'b0;
        w_done = 1'b0;
        w_err  = ERR_OK;
        w_upd  = 1'b0;
        unique case (r_phase)
            PH_TRIG_HIGH: begin
                w_trig = 1'b1;
            end
            PH_FIRST_SAMPLE: begin
                if (i_item.read_fault) begin
                    w_done = 1'b1;
                    w_err  = ERR_FAULT;
                end
            end
            PH_WAIT_RISE: begin
                if (i_item.read_fault) begin
                    w_done = 1'b1;
                    w_err  = ERR_FAULT;
                end else if (!i_item.echo && w_tmo) begin
                    w_done = 1'b1;
                    w_err  = ERR_NO_RISE;
                end
            end
            PH_MEASURE: begin
                if (i_item.read_fault) begin
                    w_done = 1'b1;
                    w_err  = ERR_FAULT;
                end else if (!i_item.echo) begin
                    w_done = 1'b1;
                    w_upd  = 1'b1;
                end else if (w_tmo) begin
                    w_done = 1'b1;
                    w_err  = ERR_TOO_LONG;
                end
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_item.start_req) begin
                    n_phase = PH_TRIG_HIGH;
                end
            end
            PH_TRIG_HIGH: begin
                n_phase = PH_FIRST_SAMPLE;
            end
            PH_FIRST_SAMPLE: begin
                n_tick  = '0;
                n_phase = i_item.echo ? PH_MEASURE : PH_WAIT_RISE;
            end
            PH_WAIT_RISE: begin
                if (i_item.echo) begin
                    n_tick  = '0;
                    n_phase = PH_MEASURE;
                end else begin
                    n_tick = r_tick + TIMEOUT_W'(1);
                end
            end
            PH_MEASURE: begin
                n_tick = r_tick + TIMEOUT_W'(1);
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
        if (w_done) begin
            n_phase = PH_IDLE;
            n_tick  = '0;
        end
    end

    always_comb begin
        n_mid.trigger = w_trig;
        n_mid.busy    = (n_phase != PH_IDLE);
        n_mid.done    = w_done;
        n_mid.err     = w_err;
        n_mid.upd     = w_upd;
        n_mid.prod    = PROD_W'(w_ticks) * PROD_W'(i_scale);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick  <= '0;
            r_mid_v <= 1'b0;
        end else begin
            if (i_load) begin
                r_mid_v <= i_in_v;
            end
            if (w_step) begin
                r_phase <= n_phase;
                r_tick  <= n_tick;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_mid <= n_mid;
        end
    end

    assign o_mid_v = r_mid_v;
    assign o_mid   = r_mid;

    `UER_ASSERT(a_done_to_idle, i_clk, i_rst_n, w_step && w_done |=> r_phase == PH_IDLE, "measurement end did not return to idle")
    `UER_ASSERT(a_trig_seq, i_clk, i_rst_n, w_step && r_phase == PH_TRIG_HIGH |=> r_phase == PH_FIRST_SAMPLE, "trigger pulse not followed by first sample")

endmodule
`default_nettype wire

### rtl/core/uer_dist.sv
// Distance divide by 100 and the result register with the held distance.
// Depends on uer_pkg and the assertion macro header.
`default_nettype none
`include "ultrasonic_echo_ranger_unit_assert.svh"
module uer_dist (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_mid_v,
    input  uer_pkg::t_mid      i_mid,
    output logic               o_out_v,
    output uer_pkg::t_out_item o_out
);
    import uer_pkg::*;

    logic                  r_out_v;
    t_out_item             r_out;
    t_out_item             n_out;
    logic [DIST_W-1:0]     r_last;
    logic [DIST_W-1:0]     n_last;
    logic [DIV_FULL_W-1:0] w_full;
    logic [DIST_W-1:0]     w_quot;

    assign w_full = DIV_FULL_W'(i_mid.prod) * DIV_FULL_W'(DIV100_MUL);
    assign w_quot = w_full[DIV100_SHIFT +: DIST_W];
    assign n_last = i_mid.upd ? w_quot : r_last;

    always_comb begin
        n_out.trigger     = i_mid.trigger;
        n_out.busy_res    = i_mid.busy;
        n_out.done_res    = i_mid.done;
        n_out.error_code  = i_mid.err;
        n_out.range_cm    = n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_last  <= '0;
        end else if (i_adv) begin
            r_out_v <= i_mid_v;
            if (i_mid_v) begin
                r_last <= n_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_mid_v) begin
            r_out <= n_out;
        end
    end

    assign o_out_v = r_out_v;
    assign o_out   = r_out;

    `UER_ASSERT(a_upd_done, i_clk, i_rst_n, i_adv && i_mid_v && i_mid.upd |=> o_out_v && o_out.done_res && o_out.error_code == ERR_OK, "distance update without clean completion")

endmodule
`default_nettype wire

### rtl/core/ultrasonic_echo_ranger_unit.sv
// Ultrasonic echo ranger top level: input register, config registers, stage control.
// A result passes the control and result registers after its input transfer.
// One tick per cycle while not stalled; stalls hold only stages whose successor is full.
// Reset: synchronous active low; idle phase, zero distance, timeout 60 ticks, scale 1716.
// Depends on uer_pkg, uer_ctrl, uer_dist and the assertion macro header.
`default_nettype none
`include "ultrasonic_echo_ranger_unit_assert.svh"
module ultrasonic_echo_ranger_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  uer_pkg::t_in_item                  i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output uer_pkg::t_out_item                 o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [uer_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import uer_pkg::*;

    logic                 r_in_v;
    t_in_item             r_in;
    logic [TIMEOUT_W-1:0] r_timeout;
    logic [SCALE_W-1:0]   r_scale;

    logic                 w_mid_v;
    t_mid                 w_mid;
    logic                 w_adv_out;
    logic                 w_adv_mid;
    logic                 w_adv_in;

    assign w_adv_out  = !o_out_valid || !i_out_stall;
    assign w_adv_mid  = !w_mid_v || w_adv_out;
    assign w_adv_in   = !r_in_v || w_adv_mid;
    assign o_in_stall = !w_adv_in;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (w_adv_in) begin
            r_in_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_in) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RST;
            r_scale   <= SCALE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_TIMEOUT: r_timeout <= i_cfg_data[TIMEOUT_W-1:0];
                REG_SCALE:   r_scale   <= i_cfg_data[SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    uer_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_adv_mid),
        .i_in_v    (r_in_v),
        .i_item    (r_in),
        .i_timeout (r_timeout),
        .i_scale   (r_scale),
        .o_mid_v   (w_mid_v),
        .o_mid     (w_mid)
    );

    uer_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv_out),
        .i_mid_v (w_mid_v),
        .i_mid   (w_mid),
        .o_out_v (o_out_valid),
        .o_out   (o_out_data)
    );

    `UER_NEVER(a_stall_empty, i_clk, i_rst_n, o_in_stall && !r_in_v, "input stalled with empty input register")

endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
// Testbench of the ultrasonic echo ranger: streams of start, echo and fault ticks go in,
// and every readout is checked against a tick-by-tick ranging model kept in this file.
// Depends on uer_pkg and ultrasonic_echo_ranger_unit.
module tb;
    import uer_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
    localparam int unsigned TICK_TARGET  = 650;
    localparam int unsigned SQUEEZE_AT   = 60;
    localparam int unsigned SQUEEZE_LEN  = 300;
    localparam int unsigned DRAIN_CYCLES = 12;

    typedef struct {
        t_in_item    tick;
        int unsigned gap;
    } t_pending;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // ranging state as the block should hold it
    t_phase               rng_phase   = PH_IDLE;
    logic [TIMEOUT_W-1:0] rng_count   = '0;
    logic [DIST_W-1:0]    rng_dist    = '0;
    logic [TIMEOUT_W-1:0] cfg_timeout = TIMEOUT_RST;
    logic [SCALE_W-1:0]   cfg_scale   = SCALE_RST;

    t_pending    tick_q[$];
    t_out_item   readout_q[$];
    int unsigned ticks_queued  = 0;
    int unsigned readouts_seen = 0;
    int unsigned errors        = 0;
    int unsigned settings      = 0;
    int unsigned ends_by_code[4] = '{0, 0, 0, 0};
    bit          send_calm     = 1'b0;

    int unsigned gap_left     = 0;
    bit          gap_armed    = 1'b0;
    int unsigned stall_left   = 0;
    int unsigned squeeze_left = 0;
    bit          squeezed     = 1'b0;

    ultrasonic_echo_ranger_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #600_000;
        $display("tb: errors");
        $finish;
    end

    function automatic int unsigned pick_gap(bit calm);
        int unsigned n;
        n = 0;
        if (!calm) begin
            case ($urandom_range(0, 3))
                0: n = 0;
                1: n = $urandom_range(0, 2);
                default: n = $urandom_range(0, 14);
            endcase
        end
        return n;
    endfunction

    function automatic bit sometimes();
        return $urandom_range(0, 3) == 0;
    endfunction

    function automatic bit coin();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic t_out_item next_readout(t_in_item t);
        t_out_item   r;
        logic        ended;
        int unsigned span;
        r = '0;
        r.error_code = ERR_OK;
        ended = 1'b0;
        case (rng_phase)
            PH_IDLE: begin
                if (t.start_req) rng_phase = PH_TRIG_HIGH;
            end
            PH_TRIG_HIGH: begin
                r.trigger = 1'b1;
                rng_phase = PH_FIRST_SAMPLE;
            end
            PH_FIRST_SAMPLE, PH_WAIT_RISE: begin
                if (t.read_fault) begin
                    ended = 1'b1;
                    r.error_code = ERR_FAULT;
                end else if (t.echo) begin
                    rng_count = '0;
                    rng_phase = PH_MEASURE;
                end else if (rng_phase == PH_WAIT_RISE && rng_count >= cfg_timeout) begin
                    ended = 1'b1;
                    r.error_code = ERR_NO_RISE;
                end else begin
                    // first sample never times out
                    rng_count = (rng_phase == PH_FIRST_SAMPLE) ? '0 : rng_count + 1'b1;
                    rng_phase = PH_WAIT_RISE;
                end
            end
            PH_MEASURE: begin
                if (t.read_fault) begin
                    ended = 1'b1;
                    r.error_code = ERR_FAULT;
                end else if (!t.echo) begin
                    span = rng_count + 1;
                    rng_dist = DIST_W'((span * cfg_scale) / 100);
                    ended = 1'b1;
                end else if (rng_count >= cfg_timeout) begin
                    ended = 1'b1;
                    r.error_code = ERR_TOO_LONG;
                end else begin
                    rng_count = rng_count + 1'b1;
                end
            end
            default: rng_phase = PH_IDLE;
        endcase
        if (ended) begin
            rng_phase = PH_IDLE;
            rng_count = '0;
            ends_by_code[r.error_code]++;
        end
        r.busy_res    = (rng_phase != PH_IDLE);
        r.done_res    = ended;
        r.range_cm    = rng_dist;
        return r;
    endfunction

    task automatic check_field(string name, logic [DIST_W-1:0] want, logic [DIST_W-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    task automatic compare_readout(t_out_item want, t_out_item got);
        check_field("trigger", DIST_W'(want.trigger), DIST_W'(got.trigger));
        check_field("busy_res", DIST_W'(want.busy_res), DIST_W'(got.busy_res));
        check_field("done_res", DIST_W'(want.done_res), DIST_W'(got.done_res));
        check_field("error_code", DIST_W'(want.error_code), DIST_W'(got.error_code));
        check_field("range_cm", want.range_cm, got.range_cm);
    endtask

    // tick source: holds each item until its transfer, then waits out the next gap
    always @(posedge i_clk) begin : feed
        t_pending cur;
        logic     nxt_valid;
        t_in_item nxt_data;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_armed = 1'b0;
            gap_left = 0;
            rng_phase = PH_IDLE;
            rng_count = '0;
            rng_dist = '0;
        end else begin
            nxt_valid = i_in_valid;
            nxt_data = i_in_data;
            if (i_in_valid && !o_in_stall) begin
                readout_q.push_back(next_readout(i_in_data));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && tick_q.size() != 0) begin
                if (!gap_armed) begin
                    gap_left = tick_q[0].gap;
                    gap_armed = 1'b1;
                end
                if (gap_left != 0) begin
                    gap_left--;
                end else begin
                    cur = tick_q.pop_front();
                    gap_armed = 1'b0;
                    nxt_valid = 1'b1;
                    nxt_data = cur.tick;
                end
            end
            i_in_valid <= nxt_valid;
            i_in_data <= nxt_data;
        end
    end

    // readout sink: random stalls, calm stretches, and one long hold-off
    always @(posedge i_clk) begin : watch
        t_out_item want;
        logic      nxt_stall;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
            squeeze_left = 0;
            squeezed = 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                readouts_seen++;
                if (readout_q.size() == 0) begin
                    errors++;
                    $display("%0t: readout %h with nothing expected", $time, o_out_data);
                end else begin
                    want = readout_q.pop_front();
                    compare_readout(want, o_out_data);
                end
                stall_left = pick_gap(readouts_seen % 160 < 40);
            end
            if (!squeezed && readouts_seen >= SQUEEZE_AT) begin
                squeezed = 1'b1;
                squeeze_left = SQUEEZE_LEN;
            end
            if (squeeze_left != 0) begin
                squeeze_left--;
                nxt_stall = 1'b1;
            end else if (stall_left != 0) begin
                stall_left--;
                nxt_stall = 1'b1;
            end else begin
                nxt_stall = 1'b0;
            end
            i_out_stall <= nxt_stall;
        end
    end

    task automatic push_tick(bit s, bit e, bit f);
        t_pending p;
        p.tick.start_req = s;
        p.tick.echo = e;
        p.tick.read_fault = f;
        p.gap = pick_gap(send_calm);
        tick_q.push_back(p);
        ticks_queued++;
    endtask

    // start, trigger high, rise_wait low samples, rise, pulse-1 high, then low
    task automatic push_measure(int rise_wait, int pulse, int fault_at);
        push_tick(1'b1, coin(), coin());
        push_tick(sometimes(), coin(), coin());
        for (int k = 0; k <= rise_wait + pulse; k++) begin
            if (k == fault_at) begin
                push_tick(sometimes(), coin(), 1'b1);
                return;
            end
            push_tick(sometimes(), k >= rise_wait && k < rise_wait + pulse, 1'b0);
        end
    endtask

    task automatic push_random_phase(int unsigned budget);
        int unsigned first;
        int          to;
        int          rise_wait;
        int          pulse;
        first = ticks_queued;
        to = int'(cfg_timeout);
        while (ticks_queued - first < budget) begin
            send_calm = ($urandom_range(0, 3) == 0);
            rise_wait = $urandom_range(0, to + 2);
            pulse = $urandom_range(1, to + 2);
            case ($urandom_range(0, 9))
                0: begin
                    repeat ($urandom_range(1, 4))
                        push_tick(sometimes(), coin(), coin());
                end
                1, 2: push_measure(rise_wait, pulse, $urandom_range(0, rise_wait + pulse));
                default: push_measure(rise_wait, pulse, -1);
            endcase
            repeat ($urandom_range(0, 2))
                push_tick(1'b0, coin(), coin());
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_TIMEOUT: cfg_timeout = val[TIMEOUT_W-1:0];
            REG_SCALE:   cfg_scale = val;
            default: ;
        endcase
    endtask

    task automatic apply_setting(int unsigned to, int unsigned sc, bit spare);
        write_reg(REG_TIMEOUT, {4'($urandom_range(0, 15)), 8'(to)});
        write_reg(REG_SCALE, 12'(sc));
        if (spare) begin
            write_reg(REG_SPARE_A, 12'($urandom_range(0, 4095)));
            write_reg(REG_SPARE_B, 12'($urandom_range(0, 4095)));
        end
        i_cfg_valid <= 1'b0;
        settings++;
    endtask

    task automatic drain();
        while (readouts_seen != ticks_queued) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int unsigned phase_no;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: echo and fault while idle, start while busy, faults
        push_tick(1'b0, 1'b1, 1'b1);
        push_tick(1'b0, 1'b0, 1'b1);
        push_tick(1'b1, 1'b0, 1'b0);
        push_tick(1'b1, 1'b1, 1'b1);
        push_tick(1'b0, 1'b1, 1'b0);
        push_tick(1'b0, 1'b1, 1'b0);
        push_tick(1'b0, 1'b1, 1'b0);
        push_tick(1'b0, 1'b0, 1'b0);
        push_tick(1'b1, 1'b0, 1'b0);
        push_tick(1'b0, 1'b0, 1'b0);
        push_tick(1'b0, 1'b1, 1'b1);
        push_measure(1, 5, 2);
        drain();

        // zero timeout and zero scale
        apply_setting(0, 0, 1'b1);
        push_measure(0, 1, -1);
        push_measure(2, 1, -1);
        push_measure(0, 2, -1);

        phase_no = 0;
        while (ticks_queued < TICK_TARGET) begin
            drain();
            case (phase_no)
                0: apply_setting(1, 4095, 1'b0);
                1: begin
                    apply_setting(255, 4095, 1'b0);
                    send_calm = 1'b1;
                    push_measure(0, 256, -1);
                    push_measure(3, 255, -1);
                end
                2: apply_setting(2, 1, 1'b1);
                default: begin
                    apply_setting($urandom_range(0, 12), $urandom_range(0, 4095), coin());
                end
            endcase
            if (phase_no != 1) push_random_phase(50);
            phase_no++;
        end
        drain();

        if (readout_q.size() != 0) begin
            errors++;
            $display("%0t: %0d readouts never arrived", $time, readout_q.size());
        end
        $display("run covered %0d ticks, %0d readouts, %0d register settings",
                 ticks_queued, readouts_seen, settings);
        $display("measurements ended: ok %0d, no rise %0d, too long %0d, read fault %0d",
                 ends_by_code[ERR_OK], ends_by_code[ERR_NO_RISE],
                 ends_by_code[ERR_TOO_LONG], ends_by_code[ERR_FAULT]);
        if (errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
